FILE: src/streaming_infix_arithmetic_evaluator_top_macros.svh
// Assertion macros shared by the evaluator modules.
`ifndef STREAMING_INFIX_ARITHMETIC_EVALUATOR_TOP_MACROS_SVH
`define STREAMING_INFIX_ARITHMETIC_EVALUATOR_TOP_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define SIA_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define SIA_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: src/sia_pkg.sv
// Shared types, codes and constants of the infix evaluator.
`default_nettype none
package sia_pkg;

    localparam int VALUE_WIDTH_DEF = 32;
    localparam int VALUE_OUT_W     = 32;
    localparam int CHAR_W          = 8;

    typedef logic signed [VALUE_OUT_W-1:0] value_out_t;

    // Parse phase
    localparam logic [1:0] PH_OPERAND = 2'd0;
    localparam logic [1:0] PH_NUMBER  = 2'd1;
    localparam logic [1:0] PH_WAITING = 2'd2;
    localparam logic [1:0] PH_DONE    = 2'd3;

    // Result status
    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_SYNTAX  = 2'd1;
    localparam logic [1:0] ST_UNKNOWN = 2'd2;
    localparam logic [1:0] ST_DIVZERO = 2'd3;

    // Characters
    localparam logic [CHAR_W-1:0] CH_PLUS  = 8'h2B;
    localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2D;
    localparam logic [CHAR_W-1:0] CH_STAR  = 8'h2A;
    localparam logic [CHAR_W-1:0] CH_SLASH = 8'h2F;
    localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
    localparam logic [CHAR_W-1:0] CH_NINE  = 8'h39;
    localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
    localparam logic [CHAR_W-1:0] CH_TAB   = 8'h09;
    localparam logic [CHAR_W-1:0] CH_CR    = 8'h0D;

    // Datapath commands
    typedef enum logic [3:0] {
        CMD_NONE,
        CMD_LATCH,
        CMD_LOAD_DIGIT,
        CMD_ACC_DIGIT,
        CMD_SET_WAIT,
        CMD_ERR_SYNTAX,
        CMD_ERR_UNKNOWN,
        CMD_ERR_DIVZERO,
        CMD_LOAD_TERM,
        CMD_START_MUL,
        CMD_START_DIV,
        CMD_MD_WRITE,
        CMD_CLOSE_DONE,
        CMD_TAKE_OP,
        CMD_CLOSE,
        CMD_EMIT
    } cmd_t;

    // Datapath status toward the controller
    typedef struct packed {
        logic       digit;
        logic       space;
        logic       oper;
        logic       eol;
        logic       err_ok;
        logic [1:0] phase;
        logic       term_started;
        logic       pend_div;
        logic       num_zero;
        logic       md_done;
        logic       out_free;
    } dp_stat_t;

endpackage
`default_nettype wire

FILE: src/sia_muldiv.sv
// Iterative one-bit-per-cycle multiplier and signed divider.
`default_nettype none
`include "streaming_infix_arithmetic_evaluator_top_macros.svh"
module sia_muldiv #(
    parameter int W = sia_pkg::VALUE_WIDTH_DEF
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         start,
    input  logic         is_div,
    input  logic [W-1:0] op_a,
    input  logic [W-1:0] op_b,
    output logic         done,
    output logic [W-1:0] result
);

    localparam int CNT_W = $clog2(W + 1);

    // x: multiplicand / divisor, y: multiplier / quotient, z: product / remainder
    logic [W-1:0]     x_reg, x_next;
    logic [W-1:0]     y_reg, y_next;
    logic [W-1:0]     z_reg, z_next;
    logic             div_reg, div_next;
    logic             neg_reg, neg_next;
    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [W-1:0]     mag_a, mag_b, z_sh;

    always_comb
    begin
        mag_a     = op_a[W-1] ? ('0 - op_a) : op_a;
        mag_b     = op_b[W-1] ? ('0 - op_b) : op_b;
        z_sh      = {z_reg[W-2:0], y_reg[W-1]};
        x_next    = x_reg;
        y_next    = y_reg;
        z_next    = z_reg;
        div_next  = div_reg;
        neg_next  = neg_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        if (start)
        begin
            div_next  = is_div;
            neg_next  = op_a[W-1] ^ op_b[W-1];
            x_next    = is_div ? mag_b : op_a;
            y_next    = is_div ? mag_a : op_b;
            z_next    = '0;
            busy_next = 1'b1;
            cnt_next  = CNT_W'(W);
        end
        else if (busy_reg)
        begin
            if (div_reg)
            begin
                if (z_sh >= x_reg)
                begin
                    z_next = z_sh - x_reg;
                    y_next = {y_reg[W-2:0], 1'b1};
                end
                else
                begin
                    z_next = z_sh;
                    y_next = {y_reg[W-2:0], 1'b0};
                end
            end
            else
            begin
                if (y_reg[0])
                begin
                    z_next = z_reg + x_reg;
                end
                x_next = {x_reg[W-2:0], 1'b0};
                y_next = {1'b0, y_reg[W-1:1]};
            end
            cnt_next = cnt_reg - CNT_W'(1);
            if (cnt_reg == CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg   <= x_next;
        y_reg   <= y_next;
        z_reg   <= z_next;
        div_reg <= div_next;
        neg_reg <= neg_next;
    end

    assign done   = done_reg;
    assign result = div_reg ? (neg_reg ? ('0 - y_reg) : y_reg) : z_reg;

    `SIA_ASSERT_NOW(a_no_start_busy, clk, rst_n, start, !busy_reg, "muldiv started while busy")
    `SIA_ASSERT_NEXT(a_done_pulse, clk, rst_n, done_reg, !done_reg && !busy_reg, "done not a pulse")

endmodule
`default_nettype wire

FILE: src/sia_datapath.sv
// Evaluator datapath: parse state, sum/term/number registers, output register.
`default_nettype none
`include "streaming_infix_arithmetic_evaluator_top_macros.svh"
module sia_datapath #(
    parameter int VALUE_WIDTH = sia_pkg::VALUE_WIDTH_DEF
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  sia_pkg::cmd_t                         cmd,
    input  logic [sia_pkg::CHAR_W-1:0]            char_code,
    input  logic                                  end_of_line,
    input  logic                                  out_stall,
    output sia_pkg::dp_stat_t                     stat,
    output logic                                  out_valid,
    output logic signed [sia_pkg::VALUE_OUT_W-1:0] value,
    output logic [1:0]                            status
);

    localparam int W = VALUE_WIDTH;

    logic [sia_pkg::CHAR_W-1:0] char_reg, char_next;
    logic                       eol_reg, eol_next;
    logic [W-1:0]               sum_reg, sum_next;
    logic [W-1:0]               term_reg, term_next;
    logic [W-1:0]               num_reg, num_next;
    logic                       minus_reg, minus_next;
    logic                       div_reg, div_next;
    logic                       started_reg, started_next;
    logic [1:0]                 phase_reg, phase_next;
    logic [1:0]                 err_reg, err_next;
    logic                       out_valid_reg, out_valid_next;
    sia_pkg::value_out_t        value_reg, value_next;
    logic [1:0]                 status_reg, status_next;

    logic                       is_digit, is_space, is_oper, err_ok, out_free;
    logic [W-1:0]               digit_val, sum_close;
    logic                       md_start, md_done;
    logic [W-1:0]               md_result;

    assign is_digit  = (char_reg >= sia_pkg::CH_ZERO) && (char_reg <= sia_pkg::CH_NINE);
    assign is_space  = (char_reg == sia_pkg::CH_SPACE)
                    || ((char_reg >= sia_pkg::CH_TAB) && (char_reg <= sia_pkg::CH_CR));
    assign is_oper   = (char_reg == sia_pkg::CH_PLUS) || (char_reg == sia_pkg::CH_MINUS)
                    || (char_reg == sia_pkg::CH_STAR) || (char_reg == sia_pkg::CH_SLASH);
    assign err_ok    = (err_reg == sia_pkg::ST_OK);
    assign out_free  = !out_valid_reg || !out_stall;
    assign digit_val = W'(char_reg[3:0]);
    assign sum_close = minus_reg ? (sum_reg - term_reg) : (sum_reg + term_reg);
    assign md_start  = (cmd == sia_pkg::CMD_START_MUL) || (cmd == sia_pkg::CMD_START_DIV);

    sia_muldiv #(
        .W (W)
    ) u_muldiv (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (md_start),
        .is_div (cmd == sia_pkg::CMD_START_DIV),
        .op_a   (term_reg),
        .op_b   (num_reg),
        .done   (md_done),
        .result (md_result)
    );

    always_comb
    begin
        char_next      = char_reg;
        eol_next       = eol_reg;
        sum_next       = sum_reg;
        term_next      = term_reg;
        num_next       = num_reg;
        minus_next     = minus_reg;
        div_next       = div_reg;
        started_next   = started_reg;
        phase_next     = phase_reg;
        err_next       = err_reg;
        value_next     = value_reg;
        status_next    = status_reg;
        out_valid_next = out_valid_reg && out_stall;
        case (cmd)
            sia_pkg::CMD_LATCH:
            begin
                char_next = char_code;
                eol_next  = end_of_line;
            end
            sia_pkg::CMD_LOAD_DIGIT:
            begin
                num_next   = digit_val;
                phase_next = sia_pkg::PH_NUMBER;
            end
            sia_pkg::CMD_ACC_DIGIT:
            begin
                // n*10 + d as two shifts and adds
                num_next = {num_reg[W-4:0], 3'b000} + {num_reg[W-2:0], 1'b0} + digit_val;
            end
            sia_pkg::CMD_SET_WAIT:
            begin
                phase_next = sia_pkg::PH_WAITING;
            end
            sia_pkg::CMD_ERR_SYNTAX:
            begin
                if (err_ok)
                begin
                    err_next = sia_pkg::ST_SYNTAX;
                end
            end
            sia_pkg::CMD_ERR_UNKNOWN:
            begin
                if (err_ok)
                begin
                    err_next = sia_pkg::ST_UNKNOWN;
                end
            end
            sia_pkg::CMD_ERR_DIVZERO:
            begin
                if (err_ok)
                begin
                    err_next = sia_pkg::ST_DIVZERO;
                end
            end
            sia_pkg::CMD_LOAD_TERM:
            begin
                term_next    = num_reg;
                started_next = 1'b1;
            end
            sia_pkg::CMD_MD_WRITE:
            begin
                term_next = md_result;
            end
            sia_pkg::CMD_CLOSE_DONE:
            begin
                sum_next     = sum_close;
                started_next = 1'b0;
                phase_next   = sia_pkg::PH_DONE;
            end
            sia_pkg::CMD_TAKE_OP:
            begin
                if ((char_reg == sia_pkg::CH_STAR) || (char_reg == sia_pkg::CH_SLASH))
                begin
                    div_next = (char_reg == sia_pkg::CH_SLASH);
                end
                else
                begin
                    sum_next     = sum_close;
                    started_next = 1'b0;
                    minus_next   = (char_reg == sia_pkg::CH_MINUS);
                end
                phase_next = sia_pkg::PH_OPERAND;
            end
            sia_pkg::CMD_CLOSE:
            begin
                sum_next     = sum_close;
                started_next = 1'b0;
            end
            sia_pkg::CMD_EMIT:
            begin
                value_next     = err_ok ? sia_pkg::value_out_t'($signed(sum_reg)) : '0;
                status_next    = err_reg;
                out_valid_next = 1'b1;
                // line done: back to the reset state
                sum_next       = '0;
                term_next      = '0;
                num_next       = '0;
                minus_next     = 1'b0;
                div_next       = 1'b0;
                started_next   = 1'b0;
                phase_next     = sia_pkg::PH_OPERAND;
                err_next       = sia_pkg::ST_OK;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_reg       <= '0;
            term_reg      <= '0;
            num_reg       <= '0;
            minus_reg     <= 1'b0;
            div_reg       <= 1'b0;
            started_reg   <= 1'b0;
            phase_reg     <= sia_pkg::PH_OPERAND;
            err_reg       <= sia_pkg::ST_OK;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            sum_reg       <= sum_next;
            term_reg      <= term_next;
            num_reg       <= num_next;
            minus_reg     <= minus_next;
            div_reg       <= div_next;
            started_reg   <= started_next;
            phase_reg     <= phase_next;
            err_reg       <= err_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        char_reg   <= char_next;
        eol_reg    <= eol_next;
        value_reg  <= value_next;
        status_reg <= status_next;
    end

    always_comb
    begin
        stat.digit        = is_digit;
        stat.space        = is_space;
        stat.oper         = is_oper;
        stat.eol          = eol_reg;
        stat.err_ok       = err_ok;
        stat.phase        = phase_reg;
        stat.term_started = started_reg;
        stat.pend_div     = div_reg;
        stat.num_zero     = (num_reg == '0);
        stat.md_done      = md_done;
        stat.out_free     = out_free;
    end

    assign out_valid = out_valid_reg;
    assign value     = value_reg;
    assign status    = status_reg;

    `SIA_ASSERT_NEXT(a_first_error_wins, clk, rst_n,
        (!err_ok && (cmd != sia_pkg::CMD_EMIT)), (err_reg == $past(err_reg)),
        "error code changed before end of line")
    `SIA_ASSERT_NOW(a_emit_slot_free, clk, rst_n, (cmd == sia_pkg::CMD_EMIT), out_free,
        "result written over an untaken result")

endmodule
`default_nettype wire

FILE: src/sia_ctrl.sv
// Evaluator controller: sequences one character through the datapath.
`default_nettype none
`include "streaming_infix_arithmetic_evaluator_top_macros.svh"
module sia_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  sia_pkg::dp_stat_t stat,
    output sia_pkg::cmd_t     cmd
);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_CHAR   = 3'd1;
    localparam logic [2:0] S_APPLY  = 3'd2;
    localparam logic [2:0] S_MD     = 3'd3;
    localparam logic [2:0] S_POST   = 3'd4;
    localparam logic [2:0] S_EOLCHK = 3'd5;
    localparam logic [2:0] S_ECLOSE = 3'd6;
    localparam logic [2:0] S_EMIT   = 3'd7;

    logic [2:0] state_reg, state_next;
    logic       ret_eol_reg, ret_eol_next;
    logic [2:0] after_apply;

    // where to resume once the number has been applied to the term
    assign after_apply = ret_eol_reg ? S_ECLOSE : S_POST;

    always_comb
    begin
        state_next   = state_reg;
        ret_eol_next = ret_eol_reg;
        cmd          = sia_pkg::CMD_NONE;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd        = sia_pkg::CMD_LATCH;
                    state_next = S_CHAR;
                end
            end
            S_CHAR:
            begin
                state_next = S_EOLCHK;
                if (!stat.err_ok || (stat.phase == sia_pkg::PH_DONE))
                begin
                    cmd = sia_pkg::CMD_NONE;
                end
                else if (stat.phase == sia_pkg::PH_OPERAND)
                begin
                    if (stat.digit)
                    begin
                        cmd = sia_pkg::CMD_LOAD_DIGIT;
                    end
                    else if (stat.oper)
                    begin
                        cmd = sia_pkg::CMD_ERR_SYNTAX;
                    end
                    else if (!stat.space)
                    begin
                        cmd = sia_pkg::CMD_ERR_UNKNOWN;
                    end
                end
                else if ((stat.phase == sia_pkg::PH_NUMBER) && stat.digit)
                begin
                    cmd = sia_pkg::CMD_ACC_DIGIT;
                end
                else if (stat.space)
                begin
                    cmd = sia_pkg::CMD_SET_WAIT;
                end
                else if (!stat.digit && !stat.oper)
                begin
                    cmd = sia_pkg::CMD_ERR_UNKNOWN;
                end
                else
                begin
                    ret_eol_next = 1'b0;
                    state_next   = S_APPLY;
                end
            end
            S_APPLY:
            begin
                if (!stat.term_started)
                begin
                    cmd        = sia_pkg::CMD_LOAD_TERM;
                    state_next = after_apply;
                end
                else if (stat.pend_div && stat.num_zero)
                begin
                    cmd        = sia_pkg::CMD_ERR_DIVZERO;
                    state_next = after_apply;
                end
                else
                begin
                    cmd        = stat.pend_div ? sia_pkg::CMD_START_DIV : sia_pkg::CMD_START_MUL;
                    state_next = S_MD;
                end
            end
            S_MD:
            begin
                if (stat.md_done)
                begin
                    cmd        = sia_pkg::CMD_MD_WRITE;
                    state_next = after_apply;
                end
            end
            S_POST:
            begin
                if (stat.err_ok)
                begin
                    cmd = stat.digit ? sia_pkg::CMD_CLOSE_DONE : sia_pkg::CMD_TAKE_OP;
                end
                state_next = S_EOLCHK;
            end
            S_EOLCHK:
            begin
                if (!stat.eol)
                begin
                    state_next = S_IDLE;
                end
                else if (!stat.err_ok || (stat.phase == sia_pkg::PH_DONE))
                begin
                    state_next = S_EMIT;
                end
                else if (stat.phase == sia_pkg::PH_OPERAND)
                begin
                    cmd        = sia_pkg::CMD_ERR_SYNTAX;
                    state_next = S_EMIT;
                end
                else
                begin
                    ret_eol_next = 1'b1;
                    state_next   = S_APPLY;
                end
            end
            S_ECLOSE:
            begin
                if (stat.err_ok)
                begin
                    cmd = sia_pkg::CMD_CLOSE;
                end
                state_next = S_EMIT;
            end
            S_EMIT:
            begin
                if (stat.out_free)
                begin
                    cmd        = sia_pkg::CMD_EMIT;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            ret_eol_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            ret_eol_reg <= ret_eol_next;
        end
    end

    assign in_stall = (state_reg != S_IDLE);

    `SIA_ASSERT_NEXT(a_busy_after_accept, clk, rst_n, (in_valid && !in_stall), in_stall,
        "new item taken while one is in work")
    `SIA_ASSERT_NOW(a_md_only_from_apply, clk, rst_n,
        ((cmd == sia_pkg::CMD_START_MUL) || (cmd == sia_pkg::CMD_START_DIV)),
        (stat.term_started && !(stat.pend_div && stat.num_zero)),
        "muldiv started without a term or on a zero divisor")

endmodule
`default_nettype wire

FILE: src/streaming_infix_arithmetic_evaluator_top.sv
// Top level of the streaming infix arithmetic evaluator.
//
// Input channel: one ASCII character per item on char_code, end_of_line high
// on the last character of a line. An item is taken when in_valid is high and
// in_stall is low. Output channel: one item per line (value, status) when
// out_valid is high and out_stall is low; value is 0 unless status is ok.
// Status: 0 ok, 1 syntax error, 2 unknown character, 3 divide by zero.
// Items are taken one at a time. A plain character (a digit that starts or
// extends a number, a blank, or anything after the expression ended or
// failed) is handled in the character step alone. A character that applies a
// waiting number also loads or updates the term, and when * or / is pending
// it runs the shared shift-add / restoring divide unit, one bit per cycle. A
// line end closes the last factor if a number is still waiting, which may
// need the unit as well; a stalled output holds the line end too.
// The output sits in a register: the next line's characters are taken while
// a result waits; if the receiver stalls, only the next line end waits.
// Reset (rst_n low, asynchronous) clears the parse state and drops out_valid.
`default_nettype none
module streaming_infix_arithmetic_evaluator_top #(
    parameter int VALUE_WIDTH = sia_pkg::VALUE_WIDTH_DEF
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   in_valid,
    output logic                                   in_stall,
    input  logic [sia_pkg::CHAR_W-1:0]             char_code,
    input  logic                                   end_of_line,
    output logic                                   out_valid,
    input  logic                                   out_stall,
    output logic signed [sia_pkg::VALUE_OUT_W-1:0] value,
    output logic [1:0]                             status
);

    sia_pkg::cmd_t     cmd;
    sia_pkg::dp_stat_t stat;

    sia_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .stat     (stat),
        .cmd      (cmd)
    );

    sia_datapath #(
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .char_code   (char_code),
        .end_of_line (end_of_line),
        .out_stall   (out_stall),
        .stat        (stat),
        .out_valid   (out_valid),
        .value       (value),
        .status      (status)
    );

endmodule
`default_nettype wire
